### src/acps_pkg.sv
// ----------------------------------------------------------------------------
// acps_pkg: shared types and constants for the anti-aliased circle shader
// Field widths, register codes, configuration bundle and pipeline tag.
// ----------------------------------------------------------------------------
package acps_pkg;

	// Pixel index width (range 4..16)
	localparam int INDEX_BITS = 12;

	// Fixed field widths
	localparam int DATA_BITS  = 64;
	localparam int COORD_BITS = 32;
	localparam int LEN_BITS   = 31;
	localparam int CH_BITS    = 16;
	localparam int COV_BITS   = CH_BITS + 1;
	localparam int ROOT_BITS  = 32;
	localparam int RAD_BITS   = 2 * ROOT_BITS;
	localparam int QUO_BITS   = CH_BITS;
	localparam int PROD_BITS  = INDEX_BITS + LEN_BITS;
	localparam int DIFF_BITS  = PROD_BITS + 2;

	// Register file geometry: 8-byte stride
	localparam int REG_COUNT  = 6;
	localparam int ADDR_BITS  = $clog2(REG_COUNT * 8);
	localparam int SEL_BITS   = ADDR_BITS - 3;

	typedef enum logic [SEL_BITS-1:0] {
		REG_COLOR  = SEL_BITS'(0),
		REG_CENTER = SEL_BITS'(1),
		REG_RADIUS = SEL_BITS'(2),
		REG_ORIGIN = SEL_BITS'(3),
		REG_WIDTH  = SEL_BITS'(4),
		REG_LAST   = SEL_BITS'(5)
	} acps_reg_t;

	// Reset values
	localparam logic [DATA_BITS-1:0]    RST_COLOR  = '1;
	localparam logic [DATA_BITS-1:0]    RST_CENTER = '0;
	localparam logic [LEN_BITS-1:0]     RST_RADIUS = LEN_BITS'(32'h0010_0000);
	localparam logic [DATA_BITS-1:0]    RST_ORIGIN = '0;
	localparam logic [LEN_BITS-1:0]     RST_WIDTH  = LEN_BITS'(32'h0001_0000);
	localparam logic [2*INDEX_BITS-1:0] RST_LAST   = '1;

	// Full coverage, 1.0 in Q1.16
	localparam logic [COV_BITS-1:0] COV_ONE = {1'b1, {CH_BITS{1'b0}}};

	// Live configuration as seen by the datapath
	typedef struct packed {
		logic [DATA_BITS-1:0]  color;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] ox;
		logic [COORD_BITS-1:0] oy;
		logic [LEN_BITS-1:0]   radius;
		logic [LEN_BITS-1:0]   width;
		logic [INDEX_BITS-1:0] last_x;
		logic [INDEX_BITS-1:0] last_y;
	} acps_cfg_t;

	// Control that travels with an item through the iterative units
	typedef struct packed {
		logic valid;
		logic live;
		logic full;
	} acps_tag_t;

endpackage

### src/acps_regs.sv
// ----------------------------------------------------------------------------
// acps_regs: configuration register file
// APB-style slave, 64-bit data, one register per 8-byte slot.
// ----------------------------------------------------------------------------
module acps_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [acps_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [acps_pkg::DATA_BITS-1:0]      pwdata,
	output logic [acps_pkg::DATA_BITS-1:0]      prdata,
	output logic                                pready,
	output acps_pkg::acps_cfg_t                 cfg
);
	import acps_pkg::*;

	logic [DATA_BITS-1:0]    color_q;
	logic [DATA_BITS-1:0]    center_q;
	logic [LEN_BITS-1:0]     radius_q;
	logic [DATA_BITS-1:0]    origin_q;
	logic [LEN_BITS-1:0]     width_q;
	logic [2*INDEX_BITS-1:0] last_q;
	logic                    wr_en;
	acps_reg_t               sel;

	assign sel    = acps_reg_t'(paddr[ADDR_BITS-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= RST_COLOR;
			center_q <= RST_CENTER;
			radius_q <= RST_RADIUS;
			origin_q <= RST_ORIGIN;
			width_q  <= RST_WIDTH;
			last_q   <= RST_LAST;
		end else if (wr_en) begin
			case (sel)
				REG_COLOR:  color_q  <= pwdata;
				REG_CENTER: center_q <= pwdata;
				REG_RADIUS: radius_q <= pwdata[LEN_BITS-1:0];
				REG_ORIGIN: origin_q <= pwdata;
				REG_WIDTH:  width_q  <= pwdata[LEN_BITS-1:0];
				REG_LAST:   last_q   <= pwdata[2*INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_COLOR:  prdata = color_q;
			REG_CENTER: prdata = center_q;
			REG_RADIUS: prdata = DATA_BITS'(radius_q);
			REG_ORIGIN: prdata = origin_q;
			REG_WIDTH:  prdata = DATA_BITS'(width_q);
			REG_LAST:   prdata = DATA_BITS'(last_q);
			default:    prdata = '0;
		endcase
	end

	// Zero width acts as one LSB
	always_comb begin
		cfg.color  = color_q;
		cfg.cx     = center_q[DATA_BITS-1:COORD_BITS];
		cfg.cy     = center_q[COORD_BITS-1:0];
		cfg.ox     = origin_q[DATA_BITS-1:COORD_BITS];
		cfg.oy     = origin_q[COORD_BITS-1:0];
		cfg.radius = radius_q;
		cfg.width  = (width_q == '0) ? LEN_BITS'(1) : width_q;
		cfg.last_x = last_q[2*INDEX_BITS-1:INDEX_BITS];
		cfg.last_y = last_q[INDEX_BITS-1:0];
	end

endmodule

### src/acps_sqrt.sv
// ----------------------------------------------------------------------------
// acps_sqrt: pipelined floor square root
// One root bit per stage, digit-by-digit with a running remainder.
// ----------------------------------------------------------------------------
module acps_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [acps_pkg::RAD_BITS-1:0]      rad,
	input  acps_pkg::acps_tag_t                tag_in,
	output logic [acps_pkg::ROOT_BITS-1:0]     root,
	output acps_pkg::acps_tag_t                tag_out
);
	import acps_pkg::*;

	localparam int REM_BITS = ROOT_BITS + 1;
	localparam int TRY_BITS = REM_BITS + 2;

	logic [REM_BITS-1:0]  rem_w  [0:ROOT_BITS-1];
	logic [RAD_BITS-1:0]  rad_w  [0:ROOT_BITS-1];
	logic [ROOT_BITS-1:0] root_w [0:ROOT_BITS];
	acps_tag_t            tag_w  [0:ROOT_BITS];

	assign rem_w[0]  = '0;
	assign rad_w[0]  = rad;
	assign root_w[0] = '0;
	assign tag_w[0]  = tag_in;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
		logic [TRY_BITS-1:0]  acc;
		logic [TRY_BITS-1:0]  trial;
		logic                 fit;
		logic [ROOT_BITS-1:0] root_s;
		acps_tag_t            tag_s;

		// bring down the next two radicand bits, try root*4+1
		assign acc   = {rem_w[k], rad_w[k][RAD_BITS-1-2*k -: 2]};
		assign trial = {1'b0, root_w[k], 2'b01};
		assign fit   = acc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s <= '0;
			end else if (adv) begin
				tag_s <= tag_w[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s <= {root_w[k][ROOT_BITS-2:0], fit};
			end
		end

		if (k < ROOT_BITS - 1) begin : g_carry
			logic [REM_BITS-1:0] rem_s;
			logic [RAD_BITS-1:0] rad_s;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s <= fit ? REM_BITS'(acc - trial) : REM_BITS'(acc);
					rad_s <= rad_w[k];
				end
			end

			assign rem_w[k+1] = rem_s;
			assign rad_w[k+1] = rad_s;
		end

		assign root_w[k+1] = root_s;
		assign tag_w[k+1]  = tag_s;
	end

	assign root    = root_w[ROOT_BITS];
	assign tag_out = tag_w[ROOT_BITS];

endmodule

### src/acps_div.sv
// ----------------------------------------------------------------------------
// acps_div: pipelined coverage divider
// Restoring division num * 2^15 / den, one quotient bit per stage, for num < 2*den.
// ----------------------------------------------------------------------------
module acps_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [acps_pkg::ROOT_BITS-1:0]     num,
	input  logic [acps_pkg::LEN_BITS-1:0]      den,
	input  acps_pkg::acps_tag_t                tag_in,
	output logic [acps_pkg::QUO_BITS-1:0]      quo,
	output acps_pkg::acps_tag_t                tag_out
);
	import acps_pkg::*;

	logic [ROOT_BITS-1:0] rem_w [0:QUO_BITS-1];
	logic [QUO_BITS-1:0]  quo_w [0:QUO_BITS];
	acps_tag_t            tag_w [0:QUO_BITS];
	logic [ROOT_BITS-1:0] den_x;

	assign den_x    = {1'b0, den};
	assign rem_w[0] = num;
	assign quo_w[0] = '0;
	assign tag_w[0] = tag_in;

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
		logic                 fit;
		logic [ROOT_BITS-1:0] diff;
		logic [QUO_BITS-1:0]  quo_s;
		acps_tag_t            tag_s;

		assign fit  = rem_w[k] >= den_x;
		assign diff = fit ? rem_w[k] - den_x : rem_w[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s <= '0;
			end else if (adv) begin
				tag_s <= tag_w[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s <= {quo_w[k][QUO_BITS-2:0], fit};
			end
		end

		if (k < QUO_BITS - 1) begin : g_carry
			logic [ROOT_BITS-1:0] rem_s;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s <= {diff[ROOT_BITS-2:0], 1'b0};
				end
			end

			assign rem_w[k+1] = rem_s;
		end

		assign quo_w[k+1] = quo_s;
		assign tag_w[k+1] = tag_s;
	end

	assign quo     = quo_w[QUO_BITS];
	assign tag_out = tag_w[QUO_BITS];

endmodule

### src/antialiased_circle_pixel_shade.sv
// ----------------------------------------------------------------------------
// antialiased_circle_pixel_shade: one pixel of an anti-aliased filled circle
// Maps a pixel index to region coordinates, measures the distance to the
// circle center and scales the fill color by the edge coverage.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ---------------------------------
//   input     in         in_valid / in_stall    pixel_x, pixel_y
//   output    out        out_valid / out_stall  red, green, blue, alpha, coverage
//   config    in/out     psel/penable/pready    paddr, pwdata, prdata (APB-style)
//
// One item enters per clock unless in_stall is high. From acceptance to the
// output register an item passes six front stages, 32 square-root stages
// (one root bit each), one stage forming the coverage numerator, 16 divider
// stages (one quotient bit each), one coverage stage and the output register.
// All stages advance together; in_stall is high exactly while a finished
// item sits in the output register and out_stall holds it there.
// Reset clears the valid bits and loads the register defaults; there is no
// clearing pass, and the bounding box test needs no stored state.
//
// The bounding box test is done per pixel without a division: with
// dx = origin + x*w - center, the pixel is inside floor/ceil bounds exactly
// when -(r+w) < dx < r+w, plus the clamping against the image edges.
// ----------------------------------------------------------------------------
module antialiased_circle_pixel_shade (
	input  logic                                clk,
	input  logic                                arst_n,
	// pixel input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [acps_pkg::INDEX_BITS-1:0]     pixel_x,
	input  logic [acps_pkg::INDEX_BITS-1:0]     pixel_y,
	// shaded output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [acps_pkg::CH_BITS-1:0]        red,
	output logic [acps_pkg::CH_BITS-1:0]        green,
	output logic [acps_pkg::CH_BITS-1:0]        blue,
	output logic [acps_pkg::CH_BITS-1:0]        alpha,
	output logic [acps_pkg::CH_BITS-1:0]        coverage,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [acps_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [acps_pkg::DATA_BITS-1:0]      pwdata,
	output logic [acps_pkg::DATA_BITS-1:0]      prdata,
	output logic                                pready
);
	import acps_pkg::*;

	// index compares against the image edge, taken at entry
	typedef struct packed {
		logic le;    // index <= last
		logic ge;    // index >= last
		logic zero;  // index == 0
	} idx_flags_t;

	acps_cfg_t cfg;
	logic      adv;

	// reach: radius + width, 32 bits unsigned
	logic [COORD_BITS-1:0] reach;
	logic [COORD_BITS-1:0] two_w;

	// stage 1: captured index
	logic                  valid_s1;
	logic [INDEX_BITS-1:0] x_s1, y_s1;
	idx_flags_t            fx_s1, fy_s1;
	// stage 2: index times width
	logic                  valid_s2;
	logic [PROD_BITS-1:0]  xw_s2, yw_s2;
	idx_flags_t            fx_s2, fy_s2;
	// stage 3: offset from the center
	logic                         valid_s3;
	logic signed [DIFF_BITS-1:0]  dx_s3, dy_s3;
	idx_flags_t                   fx_s3, fy_s3;
	// box test on stage 3, sum of squares on stage 5
	logic signed [DIFF_BITS-1:0]  reach_s;
	logic                         box_x, box_y;
	logic [RAD_BITS:0]            sum_sq;
	// stage 4: box test and saturated magnitudes
	logic                  valid_s4;
	logic                  inbox_s4;
	logic [COORD_BITS-1:0] mx_s4, my_s4;
	// stage 5: squares
	logic                  valid_s5;
	logic                  inbox_s5;
	logic [RAD_BITS-1:0]   sqx_s5, sqy_s5;
	// stage 6: saturated sum of squares
	logic                  valid_s6;
	logic                  inbox_s6;
	logic [RAD_BITS-1:0]   sum_s6;
	// square root result
	logic [ROOT_BITS-1:0]  root_dist;
	acps_tag_t             sqrt_tag_in, sqrt_tag;
	// stage 7: coverage numerator
	logic                  valid_s7, live_s7, full_s7;
	logic [ROOT_BITS-1:0]  num_s7;
	// divider result
	logic [QUO_BITS-1:0]   quo;
	acps_tag_t             div_tag_in, div_tag;
	// stage 8: clamped coverage
	logic                  valid_s8;
	logic [COV_BITS-1:0]   cov_s8;
	// stage 9: output register
	logic                  valid_s9;
	logic [CH_BITS-1:0]    red_s9, green_s9, blue_s9, alpha_s9, cov_s9;

	// channel times coverage, Q0.16
	function automatic logic [CH_BITS-1:0] scale(input logic [CH_BITS-1:0] ch,
	                                             input logic [COV_BITS-1:0] cov);
		logic [CH_BITS+COV_BITS-1:0] prod;
		prod = {{COV_BITS{1'b0}}, ch} * {{CH_BITS{1'b0}}, cov};
		return prod[2*CH_BITS-1:CH_BITS];
	endfunction

	// absolute value saturated to 32 bits
	function automatic logic [COORD_BITS-1:0] sat_mag(input logic signed [DIFF_BITS-1:0] d);
		logic [DIFF_BITS-1:0] m;
		m = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
		return (|m[DIFF_BITS-1:COORD_BITS]) ? '1 : m[COORD_BITS-1:0];
	endfunction

	acps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the whole pipe unless the output item is held
	assign adv      = !(valid_s9 && out_stall);
	assign in_stall = !adv;

	assign reach = {1'b0, cfg.radius} + {1'b0, cfg.width};
	assign two_w = {cfg.width, 1'b0};

	// Valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= sqrt_tag.valid;
			valid_s8 <= div_tag.valid;
			valid_s9 <= valid_s8;
		end
	end

	// Front: index capture, scaling, offset, box test, squares and their sum
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			x_s1       <= pixel_x;
			y_s1       <= pixel_y;
			fx_s1.le   <= pixel_x <= cfg.last_x;
			fx_s1.ge   <= pixel_x >= cfg.last_x;
			fx_s1.zero <= pixel_x == '0;
			fy_s1.le   <= pixel_y <= cfg.last_y;
			fy_s1.ge   <= pixel_y >= cfg.last_y;
			fy_s1.zero <= pixel_y == '0;

			// stage 2
			xw_s2 <= {{LEN_BITS{1'b0}}, x_s1} * {{INDEX_BITS{1'b0}}, cfg.width};
			yw_s2 <= {{LEN_BITS{1'b0}}, y_s1} * {{INDEX_BITS{1'b0}}, cfg.width};
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;

			// stage 3: exact offset from the center
			dx_s3 <= $signed({2'b00, xw_s2}) + DIFF_BITS'($signed(cfg.ox))
			         - DIFF_BITS'($signed(cfg.cx));
			dy_s3 <= $signed({2'b00, yw_s2}) + DIFF_BITS'($signed(cfg.oy))
			         - DIFF_BITS'($signed(cfg.cy));
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;

			// stage 4
			inbox_s4 <= box_x && box_y;
			mx_s4    <= sat_mag(dx_s3);
			my_s4    <= sat_mag(dy_s3);

			// stage 5
			inbox_s5 <= inbox_s4;
			sqx_s5   <= {{COORD_BITS{1'b0}}, mx_s4} * {{COORD_BITS{1'b0}}, mx_s4};
			sqy_s5   <= {{COORD_BITS{1'b0}}, my_s4} * {{COORD_BITS{1'b0}}, my_s4};

			// stage 6: saturate the sum at all ones
			inbox_s6 <= inbox_s5;
			sum_s6   <= sum_sq[RAD_BITS] ? '1 : sum_sq[RAD_BITS-1:0];
		end
	end

	// Box test: inside floor/ceil bounds, clamped to the image
	assign reach_s = $signed({{(DIFF_BITS-COORD_BITS){1'b0}}, reach});
	assign box_x = (dx_s3 > -reach_s || fx_s3.ge) && fx_s3.le
	               && (dx_s3 < reach_s || fx_s3.zero);
	assign box_y = (dy_s3 > -reach_s || fy_s3.ge) && fy_s3.le
	               && (dy_s3 < reach_s || fy_s3.zero);
	assign sum_sq = {1'b0, sqx_s5} + {1'b0, sqy_s5};

	// Distance
	assign sqrt_tag_in = '{valid: valid_s6, live: inbox_s6, full: 1'b0};

	acps_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rad     (sum_s6),
		.tag_in  (sqrt_tag_in),
		.root    (root_dist),
		.tag_out (sqrt_tag)
	);

	// Stage 7: numerator radius - d + w, drop non-positive, flag full cover
	logic signed [COORD_BITS+1:0] num;
	assign num = $signed({2'b00, reach}) - $signed({2'b00, root_dist});

	always_ff @(posedge clk) begin
		if (adv) begin
			live_s7 <= sqrt_tag.live && (num > 0);
			full_s7 <= num >= $signed({2'b00, two_w});
			num_s7  <= num[ROOT_BITS-1:0];
		end
	end

	assign div_tag_in = '{valid: valid_s7, live: live_s7, full: full_s7};

	acps_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.num     (num_s7),
		.den     (cfg.width),
		.tag_in  (div_tag_in),
		.quo     (quo),
		.tag_out (div_tag)
	);

	// Stages 8 and 9: clamp coverage, scale the color
	always_ff @(posedge clk) begin
		if (adv) begin
			if (!div_tag.live) begin
				cov_s8 <= '0;
			end else if (div_tag.full) begin
				cov_s8 <= COV_ONE;
			end else begin
				cov_s8 <= {1'b0, quo};
			end

			red_s9   <= scale(cfg.color[4*CH_BITS-1:3*CH_BITS], cov_s8);
			green_s9 <= scale(cfg.color[3*CH_BITS-1:2*CH_BITS], cov_s8);
			blue_s9  <= scale(cfg.color[2*CH_BITS-1:CH_BITS], cov_s8);
			alpha_s9 <= scale(cfg.color[CH_BITS-1:0], cov_s8);
			cov_s9   <= cov_s8[CH_BITS] ? '1 : cov_s8[CH_BITS-1:0];
		end
	end

	assign out_valid = valid_s9;
	assign red       = red_s9;
	assign green     = green_s9;
	assign blue      = blue_s9;
	assign alpha     = alpha_s9;
	assign coverage  = cov_s9;

endmodule

### src/acps_checker.sv
// ----------------------------------------------------------------------------
// acps_checker: port-level checks for the circle shader
// Watches the handshakes and the shaded outputs of the top level.
// ----------------------------------------------------------------------------
module acps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [acps_pkg::CH_BITS-1:0]  red,
	input logic [acps_pkg::CH_BITS-1:0]  green,
	input logic [acps_pkg::CH_BITS-1:0]  blue,
	input logic [acps_pkg::CH_BITS-1:0]  alpha,
	input logic [acps_pkg::CH_BITS-1:0]  coverage
);
	import acps_pkg::*;

	// Input side holds exactly when the output item is held
	a_stall_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the held output item");

	// A channel never exceeds the coverage it was scaled by
	a_chan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= coverage) && (green <= coverage)
		              && (blue <= coverage) && (alpha <= coverage))
		else $error("color channel above coverage");

	// A held item keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
		                          && $stable(blue) && $stable(alpha) && $stable(coverage))
		else $error("held output item changed");

	// Nothing comes out in the first cycle after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind antialiased_circle_pixel_shade acps_checker u_acps_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for antialiased_circle_pixel_shade
// Loads circle, color and image settings over the register port and streams
// pixel indexes through the shader. A fixed-point predictor or a hand-read
// table entry gives each shaded pixel, and every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import acps_pkg::*;

	// Run bounds
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int RANDOM_ITEMS  = 1525;
	localparam int TAIL_CYCLES   = 60;
	localparam int RESET_CYCLES  = 12;
	localparam int BYTE_BITS     = ADDR_BITS - SEL_BITS;

	// Register byte addresses, one 8-byte slot per register
	localparam logic [ADDR_BITS-1:0] A_COLOR  = {REG_COLOR,  {BYTE_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] A_CENTER = {REG_CENTER, {BYTE_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] A_RADIUS = {REG_RADIUS, {BYTE_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] A_ORIGIN = {REG_ORIGIN, {BYTE_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] A_WIDTH  = {REG_WIDTH,  {BYTE_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] A_LAST   = {REG_LAST,   {BYTE_BITS{1'b0}}};
	// Two slots past the last register; writes there must have no effect
	localparam logic [SEL_BITS-1:0]  SEL_SPARE_A = SEL_BITS'(REG_COUNT);
	localparam logic [SEL_BITS-1:0]  SEL_SPARE_B = SEL_BITS'(REG_COUNT + 1);
	localparam logic [ADDR_BITS-1:0] A_SPARE_A = {SEL_SPARE_A, {BYTE_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] A_SPARE_B = {SEL_SPARE_B, {BYTE_BITS{1'b0}}};

	// One shaded pixel, red in the top slot, coverage in the bottom slot
	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
		logic [CH_BITS-1:0] alpha;
		logic [CH_BITS-1:0] cov;
	} shade_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

	// One line of the directed table: a pixel, or a register write
	typedef struct packed {
		row_kind_e             kind;
		logic [ADDR_BITS-1:0]  addr;
		logic [DATA_BITS-1:0]  data;
		logic [INDEX_BITS-1:0] x;
		logic [INDEX_BITS-1:0] y;
		logic                  typed;
		shade_t                want;
	} plan_row_t;

	// Results that can be read off by hand
	localparam shade_t SH_NONE       = '0;
	localparam shade_t SH_WHITE      = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
	localparam shade_t SH_WHITE_HALF = '{16'd32767, 16'd32767, 16'd32767, 16'd32767,
		16'd32768};
	localparam shade_t SH_BLACK      = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF};
	// Color FFFF/0000/8000/0001 at full and at half coverage
	localparam shade_t SH_MIX        = '{16'hFFFF, 16'h0, 16'h8000, 16'h0001, 16'hFFFF};
	localparam shade_t SH_MIX_HALF   = '{16'd32767, 16'h0, 16'd16384, 16'h0, 16'd32768};

	localparam int PLAN_LEN = 42;

	// --------------------------------------------------------------------
	// Directed table. Rows with typed = 0 are checked against the predictor.
	// --------------------------------------------------------------------
	plan_row_t plan [PLAN_LEN] = '{
		// Defaults: white, radius 16 px centered on pixel (0,0), 1 px = 1.0
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd0,    1'b1, SH_WHITE},
		'{ROW_PIXEL, '0, '0, 12'd16,   12'd0,    1'b1, SH_WHITE_HALF},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd16,   1'b1, SH_WHITE_HALF},
		'{ROW_PIXEL, '0, '0, 12'd17,   12'd0,    1'b1, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4095, 12'd4095, 1'b1, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd3,    12'd4,    1'b1, SH_WHITE},
		'{ROW_PIXEL, '0, '0, 12'd12,   12'd12,   1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4095, 12'd0,    1'b1, SH_NONE},
		// Color extremes
		'{ROW_WRITE, A_COLOR, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd0,    1'b1, SH_BLACK},
		'{ROW_WRITE, A_COLOR, 64'hFFFF_0000_8000_0001, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd0,    1'b1, SH_MIX},
		'{ROW_PIXEL, '0, '0, 12'd16,   12'd0,    1'b1, SH_MIX_HALF},
		// Writes past the register file change nothing
		'{ROW_WRITE, A_SPARE_A, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_SPARE_B, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd0,    1'b1, SH_MIX},
		// Zero pixel width acts as one LSB: whole image inside the circle
		'{ROW_WRITE, A_WIDTH, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4095, 12'd4095, 1'b1, SH_MIX},
		// Extreme coordinates: distances saturate
		'{ROW_WRITE, A_CENTER, 64'h7FFF_FFFF_8000_0000, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_RADIUS, 64'h7FFF_FFFF, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_ORIGIN, 64'h8000_0000_7FFF_FFFF, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_WIDTH, 64'h7FFF_FFFF, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd0,    1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd1,    12'd0,    1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd2,    12'd0,    1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4,    12'd0,    1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4095, 12'd4095, 1'b0, SH_NONE},
		// Circle right of the image: box clamps to the last column
		'{ROW_WRITE, A_CENTER, 64'h1388_0000_0000_0000, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_RADIUS, 64'h000A_0000, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_ORIGIN, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_WIDTH, 64'h0001_0000, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4095, 12'd5,    1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd4094, 12'd5,    1'b1, SH_NONE},
		// Small image: indexes past the last row or column are blank
		'{ROW_WRITE, A_CENTER, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_RADIUS, 64'h0010_0000, '0, '0, 1'b0, SH_NONE},
		'{ROW_WRITE, A_LAST, 64'h00A_00A, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd11,   12'd0,    1'b1, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd10,   12'd0,    1'b1, SH_MIX},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd11,   1'b1, SH_NONE},
		'{ROW_WRITE, A_LAST, 64'h0, '0, '0, 1'b0, SH_NONE},
		'{ROW_PIXEL, '0, '0, 12'd0,    12'd0,    1'b1, SH_MIX},
		'{ROW_PIXEL, '0, '0, 12'd1,    12'd0,    1'b1, SH_NONE}
	};

	// --------------------------------------------------------------------
	// Block ports. Every input starts at a known value.
	// --------------------------------------------------------------------
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [INDEX_BITS-1:0] pixel_x  = '0;
	logic [INDEX_BITS-1:0] pixel_y  = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CH_BITS-1:0]    red;
	logic [CH_BITS-1:0]    green;
	logic [CH_BITS-1:0]    blue;
	logic [CH_BITS-1:0]    alpha;
	logic [CH_BITS-1:0]    coverage;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [ADDR_BITS-1:0]  paddr    = '0;
	logic [DATA_BITS-1:0]  pwdata   = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	antialiased_circle_pixel_shade dut (.*);

	// --------------------------------------------------------------------
	// Predictor state: a private copy of the registers and the pixel box
	// --------------------------------------------------------------------
	logic [DATA_BITS-1:0]    fill_color  = RST_COLOR;
	logic [DATA_BITS-1:0]    center_word = RST_CENTER;
	logic [LEN_BITS-1:0]     radius_len  = RST_RADIUS;
	logic [DATA_BITS-1:0]    origin_word = RST_ORIGIN;
	logic [LEN_BITS-1:0]     width_len   = RST_WIDTH;
	logic [2*INDEX_BITS-1:0] last_idx    = RST_LAST;
	longint box_col_lo, box_col_hi, box_row_lo, box_row_hi;

	// Expected shaded pixels, oldest first
	shade_t pending_shades [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int mismatch_count  = 0;
	int results_checked = 0;
	int pixels_sent     = 0;
	int clock_ticks     = 0;

	function automatic longint word_x(logic [DATA_BITS-1:0] word);
		return longint'($signed(word[63:32]));
	endfunction

	function automatic longint word_y(logic [DATA_BITS-1:0] word);
		return longint'($signed(word[31:0]));
	endfunction

	// A zero width counts as one LSB
	function automatic longint pixel_step();
		return (width_len == '0) ? 64'sd1 : longint'(width_len);
	endfunction

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint ceil_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a > 0)
			q++;
		return q;
	endfunction

	function automatic longint clamp_idx(longint v, logic [INDEX_BITS-1:0] last);
		if (v < 0)
			return 0;
		if (v > longint'(last))
			return longint'(last);
		return v;
	endfunction

	// Bounding box of the circle in pixel units, clamped to the image
	function automatic void refresh_box();
		longint w, r;
		w = pixel_step();
		r = longint'(radius_len);
		box_col_lo = clamp_idx(floor_div(word_x(center_word) - r - word_x(origin_word), w),
			last_idx[2*INDEX_BITS-1:INDEX_BITS]);
		box_col_hi = clamp_idx(ceil_div(word_x(center_word) + r - word_x(origin_word), w),
			last_idx[2*INDEX_BITS-1:INDEX_BITS]);
		box_row_lo = clamp_idx(floor_div(word_y(center_word) - r - word_y(origin_word), w),
			last_idx[INDEX_BITS-1:0]);
		box_row_hi = clamp_idx(ceil_div(word_y(center_word) + r - word_y(origin_word), w),
			last_idx[INDEX_BITS-1:0]);
	endfunction

	// Mirror a register write; slots past the register file are dropped
	function automatic void load_register(logic [ADDR_BITS-1:0] addr,
		logic [DATA_BITS-1:0] value);
		case (acps_reg_t'(addr[ADDR_BITS-1:BYTE_BITS]))
			REG_COLOR:  fill_color  = value;
			REG_CENTER: center_word = value;
			REG_RADIUS: radius_len  = value[LEN_BITS-1:0];
			REG_ORIGIN: origin_word = value;
			REG_WIDTH:  width_len   = value[LEN_BITS-1:0];
			REG_LAST:   last_idx    = value[2*INDEX_BITS-1:0];
			default:    return;
		endcase
		refresh_box();
	endfunction

	// Shade one pixel: distance to the center, edge coverage, scaled color
	function automatic shade_t shade_pixel(logic [INDEX_BITS-1:0] x,
		logic [INDEX_BITS-1:0] y);
		longint w, col, row, dx, dy, num, cov;
		logic [63:0] ax, ay, sq_x, sq_sum, rem, root, probe;
		logic [3:0][CH_BITS-1:0] scaled;
		logic [CH_BITS-1:0] cov_out;
		w = pixel_step();
		col = longint'(x);
		row = longint'(y);
		cov = 0;
		if (col >= box_col_lo && col <= box_col_hi && row >= box_row_lo &&
			row <= box_row_hi) begin
			dx = word_x(origin_word) + col * w - word_x(center_word);
			dy = word_y(origin_word) + row * w - word_y(center_word);
			ax = (dx < 0) ? 64'(-dx) : 64'(dx);
			ay = (dy < 0) ? 64'(-dy) : 64'(dy);
			// Saturate each magnitude to 32 bits, the sum of squares to 64
			if (ax > 64'hFFFF_FFFF)
				ax = 64'hFFFF_FFFF;
			if (ay > 64'hFFFF_FFFF)
				ay = 64'hFFFF_FFFF;
			sq_x = ax * ax;
			sq_sum = sq_x + ay * ay;
			if (sq_sum < sq_x)
				sq_sum = '1;
			// Floor square root, two bits of the radicand per step
			rem = sq_sum;
			root = '0;
			probe = 64'h1 << 62;
			while (probe > rem)
				probe = probe >> 2;
			while (probe != 0) begin
				if (rem >= root + probe) begin
					rem = rem - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			num = longint'(radius_len) - longint'(root) + w;
			if (num > 0) begin
				cov = (num * longint'(COV_ONE)) / (2 * w);
				if (cov > longint'(COV_ONE))
					cov = longint'(COV_ONE);
			end
		end
		for (int j = 0; j < 4; j++)
			scaled[3-j] = CH_BITS'((longint'(fill_color[48-16*j +: 16]) * cov) >> 16);
		cov_out = (cov > 65535) ? 16'hFFFF : CH_BITS'(cov);
		return {scaled, cov_out};
	endfunction

	// --------------------------------------------------------------------
	// Stimulus tasks
	// --------------------------------------------------------------------

	// Offer one pixel, idling first at random; record its expected shade
	// at the edge where it is accepted.
	task automatic push_pixel(input logic [INDEX_BITS-1:0] x, input logic [INDEX_BITS-1:0] y,
		input logic typed, input shade_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		do
			@(posedge clk);
		while (in_stall);
		pending_shades.push_back(typed ? want : shade_pixel(x, y));
		pixels_sent++;
	endtask

	// Drop valid and hold off until every result in flight has come out
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (pending_shades.size() != 0)
			@(posedge clk);
	endtask

	// Setup, then access until pready, then the bus returns to idle
	task automatic write_reg(input logic [ADDR_BITS-1:0] addr,
		input logic [DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		load_register(addr, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// --------------------------------------------------------------------
	// Clock, receiver stall and run limit
	// --------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the output at the rate of the current phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		clock_ticks <= clock_ticks + 1;
		if (clock_ticks == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Result check: every item taken from the output is compared with the
	// oldest expectation. Inputs were driven by nonblocking assignments, so
	// the values read here are the ones seen at this edge.
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		shade_t want;
		logic [4:0][CH_BITS-1:0] want_f, got_f;
		string field_names [5];
		field_names = '{"coverage", "alpha", "blue", "green", "red"};
		if (arst_n && out_valid && !out_stall) begin
			if (pending_shades.size() == 0) begin
				$error("shaded pixel out with none pending: red %0d green %0d blue %0d alpha %0d cov %0d",
					red, green, blue, alpha, coverage);
				mismatch_count++;
			end else begin
				want = pending_shades.pop_front();
				want_f = want;
				got_f = {red, green, blue, alpha, coverage};
				results_checked++;
				for (int i = 0; i < 5; i++) begin
					if (got_f[i] !== want_f[i]) begin
						$error("%s: expected %0d, got %0d", field_names[i], want_f[i], got_f[i]);
						mismatch_count++;
					end
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// Main sequence: reset, directed table, random phases, wrap-up
	// --------------------------------------------------------------------
	initial begin
		int phase;
		int random_sent;
		int phase_items;
		longint wv, weff, rv, oxv, oyv, cxv, cyv, lo, span, px, py;
		logic [DATA_BITS-1:0] color_d, center_d, radius_d, origin_d, width_d, last_d;
		logic [INDEX_BITS-1:0] last_x, last_y;

		refresh_box();
		// Hold reset, then release it on a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling on either side
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].kind == ROW_WRITE) begin
				drain_pixels();
				write_reg(plan[r].addr, plan[r].data);
			end else begin
				push_pixel(plan[r].x, plan[r].y, plan[r].typed, plan[r].want);
			end
		end

		// Random phases: new settings and a new idle pattern each time
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			drain_pixels();
			case (phase % 8)
				1: begin
					// Every register at its all-ones extreme
					color_d  = '1;
					center_d = '1;
					radius_d = '1;
					origin_d = '1;
					width_d  = '1;
					last_d   = '1;
				end
				2: begin
					// Every register at zero: only pixel (0,0) is in the box
					color_d  = '0;
					center_d = '0;
					radius_d = '0;
					origin_d = '0;
					width_d  = '0;
					last_d   = '0;
				end
				default: begin
					// A circle of up to a few hundred pixels somewhere on the image
					wv = ($urandom_range(7) == 0) ? longint'($urandom_range(32'h7FFF_FFFF, 1))
						: longint'($urandom_range(1 << 18, 1 << 8));
					if ($urandom_range(15) == 0)
						wv = 0;
					weff = (wv == 0) ? 1 : wv;
					rv = longint'($urandom_range(300)) * weff +
						longint'($urandom_range(32'(weff - 1)));
					if (rv > 64'sh7FFF_FFFF)
						rv = 64'sh7FFF_FFFF;
					if ($urandom_range(3) == 0) begin
						oxv = longint'($signed($urandom));
						oyv = longint'($signed($urandom));
					end else begin
						oxv = longint'($urandom_range(1 << 24)) - (1 << 23);
						oyv = longint'($urandom_range(1 << 24)) - (1 << 23);
					end
					cxv = oxv + longint'($urandom_range(4095)) * weff +
						longint'($urandom_range(32'(weff - 1)));
					cyv = oyv + longint'($urandom_range(4095)) * weff +
						longint'($urandom_range(32'(weff - 1)));
					if ($urandom_range(3) == 0) begin
						last_x = INDEX_BITS'($urandom);
						last_y = INDEX_BITS'($urandom);
					end else begin
						last_x = INDEX_BITS'(4095 - $urandom_range(63));
						last_y = INDEX_BITS'(4095 - $urandom_range(63));
					end
					color_d  = {$urandom, $urandom};
					center_d = {32'(cxv), 32'(cyv)};
					origin_d = {32'(oxv), 32'(oyv)};
					// Random bits above each narrow register must be ignored
					radius_d = {$urandom, $urandom};
					radius_d[LEN_BITS-1:0] = LEN_BITS'(rv);
					width_d  = {$urandom, $urandom};
					width_d[LEN_BITS-1:0] = LEN_BITS'(wv);
					last_d   = {$urandom, $urandom};
					last_d[2*INDEX_BITS-1:0] = {last_x, last_y};
				end
			endcase
			write_reg(A_COLOR,  color_d);
			write_reg(A_CENTER, center_d);
			write_reg(A_RADIUS, radius_d);
			write_reg(A_ORIGIN, origin_d);
			write_reg(A_WIDTH,  width_d);
			write_reg(A_LAST,   last_d);

			// Idle patterns: none, sender sparse, receiver stalling, both light
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 9;
					recv_stall_pct = 9;
				end
			endcase

			// Mostly pixels around the circle's box, some anywhere
			phase_items = $urandom_range(160, 100);
			for (int n = 0; n < phase_items && random_sent < RANDOM_ITEMS; n++) begin
				if ($urandom_range(4) != 0) begin
					lo = box_col_lo - 2;
					span = box_col_hi - box_col_lo + 4;
					px = lo + longint'($urandom_range(32'(span)));
					lo = box_row_lo - 2;
					span = box_row_hi - box_row_lo + 4;
					py = lo + longint'($urandom_range(32'(span)));
					px = (px < 0) ? 0 : ((px > 4095) ? 4095 : px);
					py = (py < 0) ? 0 : ((py > 4095) ? 4095 : py);
				end else begin
					px = longint'($urandom_range(4095));
					py = longint'($urandom_range(4095));
				end
				push_pixel(INDEX_BITS'(px), INDEX_BITS'(py), 1'b0, SH_NONE);
				random_sent++;
			end
			phase++;
		end

		// Wait out every result, then watch the output for stray items
		drain_pixels();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Shaded %0d pixels over %0d random register settings plus the directed table,",
			pixels_sent, phase);
		$display("with idle and stall phases on both sides; %0d results compared field by field.",
			results_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
